// ===== rtl/lld_pkg.sv =====
package lld_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int SLOT_W      = 4;
	localparam int OCC_W       = 5;

	localparam logic [15:0] EXPECTED_TYPE_RST = 16'd288;
	localparam logic [15:0] MIN_LENGTH        = 16'd4;
	localparam logic [3:0]  ENTRY_LAST_IDX    = 4'd11;

	// Header byte positions.
	localparam logic [3:0] HB_TYPE_HI = 4'd0;
	localparam logic [3:0] HB_TYPE_LO = 4'd1;
	localparam logic [3:0] HB_LEN_HI  = 4'd2;
	localparam logic [3:0] HB_LEN_LO  = 4'd3;
	localparam logic [3:0] HB_CNT_HI  = 4'd6;
	localparam logic [3:0] HB_CNT_LO  = 4'd7;

	// Result status codes.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_BUSY  = 3'd1;
	localparam logic [2:0] ST_DONE  = 3'd2;
	localparam logic [2:0] ST_BAD   = 3'd3;
	localparam logic [2:0] ST_SHORT = 3'd4;
	localparam logic [2:0] ST_FULL  = 3'd5;

	// Table events.
	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_NEW    = 2'd1;
	localparam logic [1:0] EV_UPDATE = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_ENTRIES
	} phase_t;

	typedef struct packed {
		logic       load;
		logic       type_hi;
		logic       type_lo;
		logic       len_hi;
		logic       len_lo;
		logic       cnt_hi;
		logic       cnt_lo;
		logic       shift_token;
		logic       shift_local;
		logic       shift_remote;
		logic       upsert;
		logic [2:0] status;
	} cmd_t;

	typedef struct packed {
		logic header_bad;
		logic count_zero;
		logic short_hdr;
		logic short_ent;
		logic last_entry;
		logic hit;
		logic free_any;
	} flags_t;

endpackage

// ===== rtl/lld_if.sv =====
interface lld_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, data_byte, first_byte, input ready);
	modport sink (input valid, data_byte, first_byte, output ready);
endinterface

interface lld_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] expected_type;

	modport source (output valid, expected_type, input ready);
	modport sink (input valid, expected_type, output ready);
endinterface

interface lld_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] parse_status;
	logic [1:0] entry_event;
	logic [3:0] entry_slot;
	logic [4:0] links_held;

	modport source (output valid, parse_status, entry_event, entry_slot, links_held,
		input ready);
	modport sink (input valid, parse_status, entry_event, entry_slot, links_held,
		output ready);
endinterface

// ===== rtl/link_list_element_decoder.sv =====
// Channel  | Direction | Carries
// elem     | in        | data_byte, first_byte
// cfg      | in        | expected_type (always ready)
// result   | out       | parse_status, entry_event, entry_slot, links_held
//
// Every request on elem yields one registered result, valid in the cycle after it is taken.
// The token match over the 16-slot table is a parallel compare done in the
// same cycle as the twelfth byte of an entry, so the lookup never stalls elem.
// A new request is taken while the previous result is being taken; a stalled
// result holds elem off. Reset clears the parser, valid bits and link count.
module link_list_element_decoder import lld_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	lld_in_if.sink    elem,
	lld_cfg_if.sink   cfg,
	lld_out_if.source result
);

	cmd_t   cmd;
	flags_t flags;

	assign cfg.ready = 1'b1;

	lld_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (elem.valid),
		.first_byte (elem.first_byte),
		.out_ready  (result.ready),
		.flags      (flags),
		.in_ready   (elem.ready),
		.out_valid  (result.valid),
		.cmd        (cmd)
	);

	lld_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (elem.data_byte),
		.cmd          (cmd),
		.cfg_valid    (cfg.valid),
		.cfg_data     (cfg.expected_type),
		.flags        (flags),
		.parse_status (result.parse_status),
		.entry_event  (result.entry_event),
		.entry_slot   (result.entry_slot),
		.links_held   (result.links_held)
	);

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.links_held <= OCC_W'(TABLE_DEPTH)))
		else $error("link count exceeds table depth");

	a_full_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.parse_status == ST_FULL) |-> (result.entry_event == EV_NONE))
		else $error("dropped entry reports a table write");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(elem.valid && elem.ready) |-> (!result.valid || result.ready))
		else $error("request taken while result is stalled");

	a_new_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(elem.valid && elem.ready) ##1 (result.entry_event == EV_NEW)
		|-> (result.links_held != 5'd0))
		else $error("inserted link not counted");

endmodule

// ===== rtl/lld_ctrl.sv =====
module lld_ctrl import lld_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  logic   first_byte,
	input  logic   out_ready,
	input  flags_t flags,
	output logic   in_ready,
	output logic   out_valid,
	output cmd_t   cmd
);

	phase_t     phase_q, phase_d, eff_phase;
	logic [3:0] idx_q, idx_d, eff_idx;
	logic       out_valid_q;
	logic       accept;
	logic       full;
	logic [2:0] fin_ent;

	// The result register frees up in the same cycle it is taken.
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// A first byte restarts the header regardless of where parsing stood.
	assign eff_phase = first_byte ? PH_HEADER : phase_q;
	assign eff_idx   = first_byte ? 4'd0 : idx_q;

	assign full    = !flags.hit && !flags.free_any;
	assign fin_ent = flags.short_ent ? ST_SHORT : ST_DONE;

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		if (accept) begin
			unique case (eff_phase)
				PH_HEADER: begin
					phase_d = PH_HEADER;
					idx_d   = eff_idx + 4'd1;
					if (eff_idx == HB_LEN_LO && flags.header_bad) begin
						phase_d = PH_IDLE;
					end else if (eff_idx == HB_CNT_LO) begin
						if (flags.count_zero) begin
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_ENTRIES;
							idx_d   = 4'd0;
						end
					end
				end
				PH_ENTRIES: begin
					if (eff_idx >= ENTRY_LAST_IDX) begin
						idx_d = 4'd0;
						if (flags.last_entry) begin
							phase_d = PH_IDLE;
						end
					end else begin
						idx_d = eff_idx + 4'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.load = accept;
		cmd.status = ST_IDLE;
		unique case (eff_phase)
			PH_HEADER: begin
				cmd.status = ST_BUSY;
				unique case (eff_idx)
					HB_TYPE_HI: cmd.type_hi = 1'b1;
					HB_TYPE_LO: cmd.type_lo = 1'b1;
					HB_LEN_HI:  cmd.len_hi  = 1'b1;
					HB_LEN_LO: begin
						cmd.len_lo = 1'b1;
						if (flags.header_bad) begin
							cmd.status = ST_BAD;
						end
					end
					HB_CNT_HI: cmd.cnt_hi = 1'b1;
					HB_CNT_LO: begin
						cmd.cnt_lo = 1'b1;
						if (flags.count_zero) begin
							cmd.status = flags.short_hdr ? ST_SHORT : ST_DONE;
						end
					end
					default: begin
					end
				endcase
			end
			PH_ENTRIES: begin
				cmd.status = ST_BUSY;
				if (eff_idx < 4'd4) begin
					cmd.shift_token = 1'b1;
				end else if (eff_idx < 4'd8) begin
					cmd.shift_local = 1'b1;
				end else begin
					cmd.shift_remote = 1'b1;
				end
				if (eff_idx >= ENTRY_LAST_IDX) begin
					cmd.upsert = 1'b1;
					cmd.status = full ? ST_FULL : ST_BUSY;
					// A short length outranks a dropped entry, which outranks done.
					if (flags.last_entry && (fin_ent == ST_SHORT || !full)) begin
						cmd.status = fin_ent;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/lld_datapath.sv =====
module lld_datapath import lld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  cmd_t        cmd,
	input  logic        cfg_valid,
	input  logic [15:0] cfg_data,
	output flags_t      flags,
	output logic [2:0]  parse_status,
	output logic [1:0]  entry_event,
	output logic [3:0]  entry_slot,
	output logic [4:0]  links_held
);

	logic [15:0] exp_type_q;
	logic [15:0] type_q, len_q, decl_q, left_q;
	logic [31:0] token_q, local_q, remote_q;
	logic [31:0] remote_next;
	logic [31:0] tok_mem [TABLE_DEPTH];
	logic [31:0] loc_mem [TABLE_DEPTH];
	logic [31:0] rem_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [OCC_W-1:0]       occ_q, occ_d;
	logic [TABLE_DEPTH-1:0] match;
	logic [SLOT_W-1:0]      hit_slot, free_slot, wr_slot;
	logic        hit, free_any, insert;
	logic [15:0] cnt_now;
	logic [19:0] need_hdr, need_ent;
	logic [1:0]  event_d;
	logic [SLOT_W-1:0] slot_d;

	logic [2:0]        status_q;
	logic [1:0]        event_q;
	logic [SLOT_W-1:0] slot_q;
	logic [OCC_W-1:0]  held_q;

	assign cnt_now = {decl_q[15:8], data_byte};

	// Length needed to cover all entries is 4 + 12 * count, built from shifts.
	assign need_hdr = 20'd4 + {1'b0, cnt_now, 3'b000} + {2'b00, cnt_now, 2'b00};
	assign need_ent = 20'd4 + {1'b0, decl_q, 3'b000} + {2'b00, decl_q, 2'b00};

	assign remote_next = {remote_q[23:0], data_byte};

	always_comb begin
		hit       = 1'b0;
		free_any  = 1'b0;
		hit_slot  = '0;
		free_slot = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			match[i] = valid_q[i] && (tok_mem[i] == token_q);
		end
		// Walk from the top down so the lowest-numbered slot wins.
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit      = 1'b1;
				hit_slot = SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				free_any  = 1'b1;
				free_slot = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		flags.header_bad = (type_q != exp_type_q) || ({len_q[15:8], data_byte} < MIN_LENGTH);
		flags.count_zero = (cnt_now == 16'd0);
		flags.short_hdr  = ({4'd0, len_q} < need_hdr);
		flags.short_ent  = ({4'd0, len_q} < need_ent);
		flags.last_entry = (left_q == 16'd1);
		flags.hit        = hit;
		flags.free_any   = free_any;
	end

	assign insert  = cmd.upsert && !hit && free_any;
	assign wr_slot = hit ? hit_slot : free_slot;
	assign occ_d   = occ_q + OCC_W'(insert);

	always_comb begin
		event_d = EV_NONE;
		slot_d  = '0;
		if (cmd.upsert) begin
			if (hit) begin
				event_d = EV_UPDATE;
				slot_d  = hit_slot;
			end else if (free_any) begin
				event_d = EV_NEW;
				slot_d  = free_slot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_type_q <= EXPECTED_TYPE_RST;
			type_q     <= '0;
			len_q      <= '0;
			decl_q     <= '0;
			left_q     <= '0;
			token_q    <= '0;
			local_q    <= '0;
			remote_q   <= '0;
			valid_q    <= '0;
			occ_q      <= '0;
		end else begin
			if (cfg_valid) begin
				exp_type_q <= cfg_data;
			end
			if (cmd.load) begin
				if (cmd.type_hi) type_q <= {data_byte, 8'h00};
				if (cmd.type_lo) type_q <= {type_q[15:8], data_byte};
				if (cmd.len_hi) len_q <= {data_byte, 8'h00};
				if (cmd.len_lo) len_q <= {len_q[15:8], data_byte};
				if (cmd.cnt_hi) decl_q <= {data_byte, 8'h00};
				if (cmd.cnt_lo) begin
					decl_q <= cnt_now;
					left_q <= cnt_now;
				end
				if (cmd.shift_token) token_q <= {token_q[23:0], data_byte};
				if (cmd.shift_local) local_q <= {local_q[23:0], data_byte};
				if (cmd.shift_remote) remote_q <= remote_next;
				if (cmd.upsert) begin
					left_q <= left_q - 16'd1;
					if (insert) begin
						valid_q[free_slot] <= 1'b1;
					end
				end
				occ_q <= occ_d;
			end
		end
	end

	// Table contents are only read behind a valid bit, so they carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.load && cmd.upsert && (hit || free_any)) begin
			tok_mem[wr_slot] <= token_q;
			loc_mem[wr_slot] <= local_q;
			rem_mem[wr_slot] <= remote_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= cmd.status;
			event_q  <= event_d;
			slot_q   <= slot_d;
			held_q   <= occ_d;
		end
	end

	assign parse_status = status_q;
	assign entry_event  = event_q;
	assign entry_slot   = slot_q;
	assign links_held   = held_q;

endmodule
